### hw/rtl/cmpr_pkg.sv
package cmpr_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int TAG_BITS   = 16;

  // Manifold geometry
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COUNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int NUM_AXES  = 3;
  localparam int NUM_PAIRS = 3;
  localparam int PAIR_W    = $clog2(NUM_PAIRS);
  localparam int LAST_PAIR = NUM_PAIRS - 1;

  // One diagonal pairing: 6 cross products, 9 square partials and a drain step
  localparam int STEPS     = 16;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int LAST_STEP = STEPS - 1;

  // Exact intermediate widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int MUL_W   = DIFF_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int MAG_W   = 2 * DIFF_W;
  localparam int AREA_W  = 4 * DIFF_W + 2;
  localparam int SH_HH   = 2 * DIFF_W;
  localparam int SH_HL   = DIFF_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [TAG_BITS-1:0]          tag_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [MUL_W-1:0]      mul_op_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [AREA_W-1:0]            area_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // What a multiplier slot computes
  typedef enum logic [2:0] {
    OP_CROSS_A,   // u[a] * v[b]
    OP_CROSS_B,   // u[b] * v[a]
    OP_SQ_HH,     // hi * hi of |cross|
    OP_SQ_HL,     // hi * lo of |cross|
    OP_SQ_LL      // lo * lo of |cross|
  } op_t;

  // Tag that travels with an operand pair through the multiplier
  typedef struct packed {
    logic  valid;
    op_t   op;
    axis_t comp;
  } mul_tag_t;

  function automatic coord_t coord_of(point_t p, axis_t ax);
    coord_t c;
    unique case (ax)
      AXIS_X:  c = p.x;
      AXIS_Y:  c = p.y;
      AXIS_Z:  c = p.z;
      default: c = p.x;
    endcase
    return c;
  endfunction

  // (k+1) mod 3
  function automatic axis_t axis_next(axis_t ax);
    axis_t r;
    unique case (ax)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_Z;
      AXIS_Z:  r = AXIS_X;
      default: r = AXIS_Y;
    endcase
    return r;
  endfunction

  // (k+2) mod 3
  function automatic axis_t axis_prev(axis_t ax);
    axis_t r;
    unique case (ax)
      AXIS_X:  r = AXIS_Z;
      AXIS_Y:  r = AXIS_X;
      AXIS_Z:  r = AXIS_Y;
      default: r = AXIS_Z;
    endcase
    return r;
  endfunction

  // Issue schedule within one pairing
  function automatic mul_tag_t step_tag(logic [STEP_W-1:0] s);
    mul_tag_t t;
    t.valid = 1'b1;
    unique case (s)
      4'd0:    begin t.op = OP_CROSS_A; t.comp = AXIS_X; end
      4'd1:    begin t.op = OP_CROSS_B; t.comp = AXIS_X; end
      4'd2:    begin t.op = OP_CROSS_A; t.comp = AXIS_Y; end
      4'd3:    begin t.op = OP_CROSS_B; t.comp = AXIS_Y; end
      4'd4:    begin t.op = OP_CROSS_A; t.comp = AXIS_Z; end
      4'd5:    begin t.op = OP_CROSS_B; t.comp = AXIS_Z; end
      4'd6:    begin t.op = OP_SQ_HH;   t.comp = AXIS_X; end
      4'd7:    begin t.op = OP_SQ_HL;   t.comp = AXIS_X; end
      4'd8:    begin t.op = OP_SQ_LL;   t.comp = AXIS_X; end
      4'd9:    begin t.op = OP_SQ_HH;   t.comp = AXIS_Y; end
      4'd10:   begin t.op = OP_SQ_HL;   t.comp = AXIS_Y; end
      4'd11:   begin t.op = OP_SQ_LL;   t.comp = AXIS_Y; end
      4'd12:   begin t.op = OP_SQ_HH;   t.comp = AXIS_Z; end
      4'd13:   begin t.op = OP_SQ_HL;   t.comp = AXIS_Z; end
      4'd14:   begin t.op = OP_SQ_LL;   t.comp = AXIS_Z; end
      default: begin t.valid = 1'b0; t.op = OP_CROSS_A; t.comp = AXIS_X; end
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/contact_manifold_point_reduction_unit.sv
// Contact manifold reduction: keeps up to four contacts (point, depth, tag).
// Input channel: drive point_x/y/z, pen_depth and contact_tag with start high;
// the word is taken at the rising edge where start is high and busy is low.
// busy then stays high until the result is out; start is ignored meanwhile.
// Result channel: done is high for exactly one cycle with slot_written,
// replaced, evicted_tag, contact_count and deepest_slot valid in that cycle.
// There is no back-pressure: the receiver must take the word when done rises.
// While fewer than four contacts are held, the word passes through the write
// and report states to done. With four held, the shared 18x18 multiplier does
// 15 products per diagonal pairing, 3 pairings per candidate slot, with a
// load state before each slot; a slot protected by greater depth is skipped
// as a candidate. busy falls in the cycle done rises, so the next word can be
// accepted in that cycle.
// Reset (rst, synchronous) empties the manifold: the contact count is zero and
// slot contents are left as they are; they are rewritten before being read.
module contact_manifold_point_reduction_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  cmpr_pkg::coord_t               point_x,
  input  cmpr_pkg::coord_t               point_y,
  input  cmpr_pkg::coord_t               point_z,
  input  cmpr_pkg::coord_t               pen_depth,
  input  cmpr_pkg::tag_t                 contact_tag,
  output logic                           busy,
  output logic                           done,
  output logic [cmpr_pkg::SLOT_W-1:0]    slot_written,
  output logic                           replaced,
  output cmpr_pkg::tag_t                 evicted_tag,
  output logic [cmpr_pkg::COUNT_W-1:0]   contact_count,
  output logic [cmpr_pkg::SLOT_W-1:0]    deepest_slot
);
  import cmpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROT,
    S_LOAD,
    S_RUN,
    S_FINISH,
    S_WRITE,
    S_REPORT
  } state_t;

  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [COUNT_W-1:0] FULL      = COUNT_W'(NUM_SLOTS);

  state_t state;

  // Slot storage
  point_t slot_pts [NUM_SLOTS];
  coord_t slot_dep [NUM_SLOTS];
  tag_t   slot_tag [NUM_SLOTS];
  logic [COUNT_W-1:0] fill_count;

  // Captured input word
  point_t new_pt;
  coord_t new_dep;
  tag_t   new_tag;

  // Sequencer registers
  logic [SLOT_W-1:0] prot, cur_slot, acc_slot, pick, wslot;
  logic              prot_valid, pending, repl;
  logic [PAIR_W-1:0] pair;
  logic [STEP_W-1:0] step;

  // Quad positions 1..3; position 0 is the new point
  point_t qb, qc, qd;

  // Arithmetic datapath
  cross_t   cross_tmp;
  cross_t   cross_v [NUM_AXES];
  area_t    acc, best, sq_term;
  mul_tag_t iss_tag, res_tag;
  mul_op_t  op_a, op_b;
  prod_t    prod;

  // Combinational helpers
  logic [SLOT_W-1:0] prot_n, deep_n;
  logic              prot_valid_n, take;
  coord_t            best_d, deep_d;
  axis_t             ax_u, ax_v;
  diff_t             du, dv;
  cross_t            sq_src;
  mag_t              mag;
  logic [DIFF_W-1:0] hi, lo;

  // Protected slot: deepest held contact strictly deeper than the new one
  always_comb begin
    best_d       = new_dep;
    prot_n       = '0;
    prot_valid_n = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_dep[i] > best_d) begin
        best_d       = slot_dep[i];
        prot_n       = SLOT_W'(i);
        prot_valid_n = 1'b1;
      end
    end
  end

  // Deepest held slot, first on ties
  always_comb begin
    deep_d = slot_dep[0];
    deep_n = '0;
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if ((COUNT_W'(i) < fill_count) && (slot_dep[i] > deep_d)) begin
        deep_d = slot_dep[i];
        deep_n = SLOT_W'(i);
      end
    end
  end

  // Finished pairing measure beats the best so far
  assign take = pending && (acc > best);

  // Operand selection for the shared multiplier
  always_comb begin
    iss_tag = step_tag(step);
    if (state != S_RUN) begin
      iss_tag.valid = 1'b0;
    end
    ax_u   = (iss_tag.op == OP_CROSS_A) ? axis_next(iss_tag.comp) : axis_prev(iss_tag.comp);
    ax_v   = (iss_tag.op == OP_CROSS_A) ? axis_prev(iss_tag.comp) : axis_next(iss_tag.comp);
    du     = diff_t'(coord_of(new_pt, ax_u)) - diff_t'(coord_of(qb, ax_u));
    dv     = diff_t'(coord_of(qc, ax_v)) - diff_t'(coord_of(qd, ax_v));
    sq_src = cross_v[iss_tag.comp];
    mag    = sq_src[CROSS_W-1] ? mag_t'(-sq_src) : mag_t'(sq_src);
    hi     = mag[MAG_W-1:DIFF_W];
    lo     = mag[DIFF_W-1:0];
    unique case (iss_tag.op)
      OP_CROSS_A, OP_CROSS_B: begin
        op_a = mul_op_t'(du);
        op_b = mul_op_t'(dv);
      end
      OP_SQ_HH: begin
        op_a = {1'b0, hi};
        op_b = {1'b0, hi};
      end
      OP_SQ_HL: begin
        op_a = {1'b0, hi};
        op_b = {1'b0, lo};
      end
      OP_SQ_LL: begin
        op_a = {1'b0, lo};
        op_b = {1'b0, lo};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  cmpr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .op_a    (op_a),
    .op_b    (op_b),
    .tag_in  (iss_tag),
    .prod    (prod),
    .tag_out (res_tag)
  );

  // Square partial, placed at its weight
  always_comb begin
    unique case (res_tag.op)
      OP_SQ_HH: sq_term = area_t'(prod[MAG_W-1:0]) << SH_HH;
      OP_SQ_HL: sq_term = area_t'(prod[MAG_W-1:0]) << SH_HL;
      default:  sq_term = area_t'(prod[MAG_W-1:0]);
    endcase
  end

  // Quad positions, cross components and the pairing accumulator
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      qb <= (cur_slot == SLOT_W'(0)) ? slot_pts[1] : slot_pts[0];
      qc <= (cur_slot <= SLOT_W'(1)) ? slot_pts[2] : slot_pts[1];
      qd <= (cur_slot <= SLOT_W'(2)) ? slot_pts[3] : slot_pts[2];
    end else if (state == S_RUN && step == STEP_W'(LAST_STEP) && pair != PAIR_W'(LAST_PAIR)) begin
      // next pairing: (0,2,1,3) then (0,3,1,2)
      if (pair == PAIR_W'(0)) begin
        qb <= qc;
        qc <= qb;
      end else begin
        qb <= qd;
        qd <= qb;
      end
    end

    if (res_tag.valid) begin
      unique case (res_tag.op)
        OP_CROSS_A: cross_tmp <= cross_t'(prod);
        OP_CROSS_B: cross_v[res_tag.comp] <= cross_tmp - cross_t'(prod);
        default: ;
      endcase
    end

    priority if (state == S_RUN && step == '0) begin
      acc <= '0;
    end else if (res_tag.valid && res_tag.op != OP_CROSS_A && res_tag.op != OP_CROSS_B) begin
      acc <= acc + sq_term;
    end
  end

  // Slot store write
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      slot_pts[wslot] <= new_pt;
      slot_dep[wslot] <= new_dep;
      slot_tag[wslot] <= new_tag;
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      done       <= 1'b0;
      fill_count <= '0;
      pending    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            new_pt  <= '{x: point_x, y: point_y, z: point_z};
            new_dep <= pen_depth;
            new_tag <= contact_tag;
            busy    <= 1'b1;
            if (fill_count < FULL) begin
              wslot <= fill_count[SLOT_W-1:0];
              repl  <= 1'b0;
              state <= S_WRITE;
            end else begin
              state <= S_PROT;
            end
          end
        end
        S_PROT: begin
          prot       <= prot_n;
          prot_valid <= prot_valid_n;
          cur_slot   <= '0;
          best       <= '0;
          pick       <= '0;
          pending    <= 1'b0;
          state      <= S_LOAD;
        end
        S_LOAD: begin
          if (prot_valid && cur_slot == prot) begin
            // protected slot is never a candidate
            if (cur_slot == LAST_SLOT) begin
              state <= S_FINISH;
            end else begin
              cur_slot <= cur_slot + 1'b1;
            end
          end else begin
            pair  <= '0;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          step <= step + 1'b1;
          if (step == '0) begin
            if (take) begin
              best <= acc;
              pick <= acc_slot;
            end
            acc_slot <= cur_slot;
            pending  <= 1'b1;
          end
          if (step == STEP_W'(LAST_STEP)) begin
            if (pair == PAIR_W'(LAST_PAIR)) begin
              if (cur_slot == LAST_SLOT) begin
                state <= S_FINISH;
              end else begin
                cur_slot <= cur_slot + 1'b1;
                state    <= S_LOAD;
              end
            end else begin
              pair <= pair + 1'b1;
            end
          end
        end
        S_FINISH: begin
          wslot   <= take ? acc_slot : pick;
          repl    <= 1'b1;
          pending <= 1'b0;
          state   <= S_WRITE;
        end
        S_WRITE: begin
          evicted_tag <= repl ? slot_tag[wslot] : '0;
          if (!repl) begin
            fill_count <= fill_count + 1'b1;
          end
          state <= S_REPORT;
        end
        S_REPORT: begin
          done          <= 1'b1;
          busy          <= 1'b0;
          slot_written  <= wslot;
          replaced      <= repl;
          contact_count <= fill_count;
          deepest_slot  <= deep_n;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe without a word in progress");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (contact_count != '0 && contact_count <= FULL))
    else $error("contact count out of range");

  a_replace_full: assert property (@(posedge clk) disable iff (rst)
    (done && replaced) |-> (contact_count == FULL))
    else $error("replacement before the manifold is full");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !replaced) |-> (evicted_tag == '0))
    else $error("evicted tag set on an append");

endmodule

### hw/rtl/cmpr_mul.sv
module cmpr_mul (
  input  logic               clk,
  input  logic               rst,
  input  cmpr_pkg::mul_op_t  op_a,
  input  cmpr_pkg::mul_op_t  op_b,
  input  cmpr_pkg::mul_tag_t tag_in,
  output cmpr_pkg::prod_t    prod,
  output cmpr_pkg::mul_tag_t tag_out
);
  import cmpr_pkg::*;

  // Shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= prod_t'(op_a) * prod_t'(op_b);
  end

  // Tag is registered alongside the product
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '{valid: 1'b0, op: OP_CROSS_A, comp: AXIS_X};
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule
